// File: sv/bot_pkg.sv
// ----------------------------------------------------------------------------
// bot_pkg: shared types and codes for the bulk-only CBW to CSW decoder
// Holds the channel transfer structs, the stage-to-stage structs, and the
// opcode, status and data source codes used by the pipeline stages.
// ----------------------------------------------------------------------------
package bot_pkg;

    // Wrapper framing
    localparam logic [31:0] CBW_SIG  = 32'h4342_5355;
    localparam logic [9:0]  CBW_SIZE = 10'd31;

    // SCSI opcodes
    localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
    localparam logic [7:0] OP_INQUIRY         = 8'h12;
    localparam logic [7:0] OP_READ_FMT_CAP    = 8'h23;
    localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
    localparam logic [7:0] OP_MODE_SENSE6     = 8'h1a;
    localparam logic [7:0] OP_READ10          = 8'h28;

    // Inquiry vital product data page for the unit serial number
    localparam logic [7:0] VPD_SERIAL_PAGE = 8'h80;

    // Fixed reply lengths
    localparam logic [5:0] INQUIRY_LEN    = 6'd36;
    localparam logic [5:0] SERIAL_LEN     = 6'd12;
    localparam logic [5:0] FMT_CAP_LEN    = 6'd12;
    localparam logic [5:0] CAPACITY_LEN   = 6'd8;
    localparam logic [5:0] MODE_HDR_LEN   = 6'd4;

    // CSW status codes
    localparam logic [1:0] ST_PASS  = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_PHASE = 2'd2;

    // Data phase sources
    localparam logic [2:0] SRC_NONE     = 3'd0;
    localparam logic [2:0] SRC_INQUIRY  = 3'd1;
    localparam logic [2:0] SRC_SERIAL   = 3'd2;
    localparam logic [2:0] SRC_FMT_CAP  = 3'd3;
    localparam logic [2:0] SRC_CAPACITY = 3'd4;
    localparam logic [2:0] SRC_MODE_HDR = 3'd5;
    localparam logic [2:0] SRC_SECTORS  = 3'd6;

    // Result kinds
    localparam logic KIND_CSW     = 1'b0;
    localparam logic KIND_INVALID = 1'b1;

    typedef struct packed {
        logic [9:0]  transfer_bytes;
        logic [31:0] cbw_signature;
        logic [31:0] cbw_tag;
        logic [31:0] host_length;
        logic        host_dir_in;
        logic [63:0] cdb_head;
        logic [7:0]  cdb_byte8;
    } cbw_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] csw_tag;
        logic [31:0] csw_residue;
        logic [1:0]  csw_status;
        logic        halt_in;
        logic        halt_out;
        logic [2:0]  data_source;
        logic [24:0] data_length;
        logic [31:0] read_lba;
        logic [15:0] sector_count;
    } csw_t;

    // Decode stage result
    typedef struct packed {
        logic        bad;
        logic        known;
        logic        dev_in;
        logic        is_read;
        logic [5:0]  short_len;
        logic [2:0]  src;
        logic [31:0] tag;
        logic [31:0] host_length;
        logic        host_dir_in;
        logic [31:0] lba;
        logic [15:0] cnt;
    } dec_t;

    // Length stage result
    typedef struct packed {
        logic        bad;
        logic        known;
        logic        dev_in;
        logic        host_zero;
        logic [31:0] dev_length;
        logic [2:0]  src;
        logic [31:0] tag;
        logic [31:0] host_length;
        logic        host_dir_in;
        logic [31:0] lba;
        logic [15:0] cnt;
    } scl_t;

endpackage

// File: sv/bulk_only_cbw_to_csw.sv
// ----------------------------------------------------------------------------
// bulk_only_cbw_to_csw: USB mass storage bulk-only CBW to CSW decoder
// Checks a received command block wrapper, decodes its SCSI command and
// produces the command status wrapper fields and a data phase descriptor.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+------------------------------
//  cbw     | in        | cbw_valid / cbw_stall  | cbw_t, one command wrapper
//  csw     | out       | csw_valid / csw_stall  | csw_t, one status wrapper
//
//  Stages: three register stages (decode, length scale, case classify); a
//  wrapper is registered in each of them in that order before it is
//  offered on csw. One wrapper per cycle is sustained while csw_stall
//  stays low.
//  The read 10 length multiply sits alone in the length stage.
//  Reset: rst_n clears the stage valid bits only; payload registers hold.
//  Stalls: each stage refills as soon as its content moves on, so empty
//  stages keep taking wrappers while a finished status waits on csw_stall.
//
module bulk_only_cbw_to_csw
    import bot_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cbw_valid,
    output logic cbw_stall,
    input  cbw_t cbw,
    output logic csw_valid,
    input  logic csw_stall,
    output csw_t csw
);

    logic dec_valid;
    logic dec_stall;
    dec_t dec_data;
    logic scl_valid;
    logic scl_stall;
    scl_t scl_data;

    // Stage 1: validate the wrapper and decode the opcode
    bot_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cbw_valid),
        .up_data  (cbw),
        .up_stall (cbw_stall),
        .dn_valid (dec_valid),
        .dn_data  (dec_data),
        .dn_stall (dec_stall)
    );

    // Stage 2: scale read 10 block count into a byte length
    bot_scale #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dec_valid),
        .up_data  (dec_data),
        .up_stall (dec_stall),
        .dn_valid (scl_valid),
        .dn_data  (scl_data),
        .dn_stall (scl_stall)
    );

    // Stage 3: classify the case and hold the status wrapper for transfer
    bot_classify u_classify (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (scl_valid),
        .up_data  (scl_data),
        .up_stall (scl_stall),
        .dn_valid (csw_valid),
        .dn_data  (csw),
        .dn_stall (csw_stall)
    );

    // An invalid wrapper carries nothing but its kind
    a_invalid_clear: assert property (@(posedge clk) disable iff (!rst_n)
        csw_valid && csw.result_kind == KIND_INVALID |->
            csw.csw_tag == '0 && csw.csw_residue == '0 && csw.csw_status == ST_PASS &&
            csw.data_source == SRC_NONE && csw.data_length == '0 &&
            !csw.halt_in && !csw.halt_out)
        else $error("invalid wrapper result carries nonzero fields");

    // Only one bulk endpoint is ever stalled for a status wrapper
    a_one_stall: assert property (@(posedge clk) disable iff (!rst_n)
        csw_valid |-> !(csw.halt_in && csw.halt_out))
        else $error("both endpoints stalled");

    // Status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        csw_valid |-> csw.csw_status != 2'd3)
        else $error("undefined status code");

    // A block count comes only with the sector data source
    a_sector_src: assert property (@(posedge clk) disable iff (!rst_n)
        csw_valid && csw.sector_count != '0 |-> csw.data_source == SRC_SECTORS)
        else $error("sector count without read data source");

    // A failed command moves no data and stalls nothing
    a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        csw_valid && csw.csw_status == ST_FAIL |->
            csw.data_source == SRC_NONE && csw.data_length == '0 &&
            !csw.halt_in && !csw.halt_out)
        else $error("failed command describes a data phase");

endmodule

// File: sv/bot_decode.sv
// ----------------------------------------------------------------------------
// bot_decode: wrapper check and opcode decode stage
// Validates length and signature, decodes the SCSI opcode into direction,
// short reply length and data source, and extracts the read 10 fields.
// ----------------------------------------------------------------------------
module bot_decode
    import bot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    input  cbw_t  up_data,
    output logic  up_stall,
    output logic  dn_valid,
    output dec_t  dn_data,
    input  logic  dn_stall
);

    logic valid_reg;
    logic valid_next;
    dec_t data_reg;
    dec_t data_next;
    logic advance;

    logic [7:0]  op;
    logic [7:0]  cdb [8];
    logic [15:0] inq_alloc;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            cdb[k] = up_data.cdb_head[8*k +: 8];
        end
    end

    assign op        = cdb[0];
    assign inq_alloc = {cdb[3], cdb[4]};

    always_comb
    begin
        data_next             = '0;
        data_next.tag         = up_data.cbw_tag;
        data_next.host_length = up_data.host_length;
        data_next.host_dir_in = up_data.host_dir_in;
        data_next.known       = 1'b1;
        unique case (op)
            OP_INQUIRY:
            begin
                data_next.dev_in = 1'b1;
                if (cdb[1][0])
                begin
                    if (cdb[2] == VPD_SERIAL_PAGE)
                    begin
                        data_next.short_len = SERIAL_LEN;
                        data_next.src       = SRC_SERIAL;
                    end
                end
                else
                begin
                    data_next.short_len = (inq_alloc < 16'(INQUIRY_LEN))
                                        ? inq_alloc[5:0] : INQUIRY_LEN;
                    data_next.src       = SRC_INQUIRY;
                end
            end
            OP_TEST_UNIT_READY: ;
            OP_READ_FMT_CAP:
            begin
                data_next.dev_in    = 1'b1;
                data_next.short_len = FMT_CAP_LEN;
                data_next.src       = SRC_FMT_CAP;
            end
            OP_READ_CAPACITY:
            begin
                data_next.dev_in    = 1'b1;
                data_next.short_len = CAPACITY_LEN;
                data_next.src       = SRC_CAPACITY;
            end
            OP_MODE_SENSE6:
            begin
                data_next.dev_in    = 1'b1;
                data_next.short_len = (cdb[4] >= 8'(MODE_HDR_LEN))
                                    ? MODE_HDR_LEN : cdb[4][5:0];
                data_next.src       = SRC_MODE_HDR;
            end
            OP_READ10:
            begin
                data_next.dev_in  = 1'b1;
                data_next.is_read = 1'b1;
                data_next.src     = SRC_SECTORS;
                data_next.lba     = {cdb[2], cdb[3], cdb[4], cdb[5]};
                data_next.cnt     = {cdb[7], up_data.cdb_byte8};
            end
            default:
            begin
                data_next.known = 1'b0;
            end
        endcase
        // Drop everything for a malformed wrapper
        if (up_data.transfer_bytes != CBW_SIZE || up_data.cbw_signature != CBW_SIG)
        begin
            data_next     = '0;
            data_next.bad = 1'b1;
        end
    end

    assign advance    = !valid_reg || !dn_stall;
    assign valid_next = advance ? up_valid : valid_reg;
    assign up_stall   = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: sv/bot_scale.sv
// ----------------------------------------------------------------------------
// bot_scale: device length stage
// Scales the read 10 block count by the block size and flags a zero host
// length for the case classification that follows.
// ----------------------------------------------------------------------------
module bot_scale
    import bot_pkg::*;
#(
    parameter int BLOCK_BYTES = 512
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    input  dec_t  up_data,
    output logic  up_stall,
    output logic  dn_valid,
    output scl_t  dn_data,
    input  logic  dn_stall
);

    logic        valid_reg;
    logic        valid_next;
    scl_t        data_reg;
    scl_t        data_next;
    logic        advance;
    logic [31:0] sector_bytes;

    assign sector_bytes = 32'(up_data.cnt) * 32'(BLOCK_BYTES);

    always_comb
    begin
        data_next.bad         = up_data.bad;
        data_next.known       = up_data.known;
        data_next.dev_in      = up_data.dev_in;
        data_next.host_zero   = (up_data.host_length == '0);
        data_next.dev_length  = up_data.is_read ? sector_bytes : 32'(up_data.short_len);
        data_next.src         = up_data.src;
        data_next.tag         = up_data.tag;
        data_next.host_length = up_data.host_length;
        data_next.host_dir_in = up_data.host_dir_in;
        data_next.lba         = up_data.lba;
        data_next.cnt         = up_data.cnt;
    end

    assign advance    = !valid_reg || !dn_stall;
    assign valid_next = advance ? up_valid : valid_reg;
    assign up_stall   = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: sv/bot_classify.sv
// ----------------------------------------------------------------------------
// bot_classify: bulk-only case classification and CSW output stage
// Sorts host expectation against device intent into the thirteen cases,
// forms status, residue and stall flags, and holds the status wrapper.
// ----------------------------------------------------------------------------
module bot_classify
    import bot_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    input  scl_t  up_data,
    output logic  up_stall,
    output logic  dn_valid,
    output csw_t  dn_data,
    input  logic  dn_stall
);

    logic valid_reg;
    logic valid_next;
    csw_t data_reg;
    csw_t data_next;
    logic advance;

    logic [31:0] diff;
    logic        host_more;
    logic        host_equal;

    assign diff       = up_data.host_length - up_data.dev_length;
    assign host_more  = up_data.host_length > up_data.dev_length;
    assign host_equal = up_data.host_length == up_data.dev_length;

    always_comb
    begin
        data_next              = '0;
        data_next.result_kind  = KIND_CSW;
        data_next.csw_tag      = up_data.tag;
        data_next.csw_status   = ST_PASS;
        data_next.data_source  = up_data.src;
        data_next.data_length  = up_data.dev_length[24:0];
        data_next.read_lba     = up_data.lba;
        data_next.sector_count = up_data.cnt;
        priority if (!up_data.known)
        begin
            data_next.csw_status  = ST_FAIL;
            data_next.csw_residue = up_data.host_length;
        end
        else if (up_data.host_zero)
        begin
            data_next.csw_status = up_data.dev_in ? ST_PHASE : ST_PASS;
        end
        else if (up_data.host_dir_in)
        begin
            priority if (!up_data.dev_in)
            begin
                data_next.halt_in     = 1'b1;
                data_next.csw_residue = up_data.host_length;
            end
            else if (host_more)
            begin
                data_next.halt_in     = 1'b1;
                data_next.csw_residue = diff;
            end
            else if (host_equal)
            begin
                data_next.csw_residue = '0;
            end
            else
            begin
                data_next.csw_status  = ST_PHASE;
                data_next.csw_residue = up_data.host_length;
            end
        end
        else
        begin
            data_next.halt_out = 1'b1;
            if (up_data.dev_in)
            begin
                data_next.csw_status = ST_PHASE;
            end
            else
            begin
                data_next.csw_residue = up_data.host_length;
            end
        end
        // Report a malformed wrapper with every other field cleared
        if (up_data.bad)
        begin
            data_next             = '0;
            data_next.result_kind = KIND_INVALID;
        end
    end

    assign advance    = !valid_reg || !dn_stall;
    assign valid_next = advance ? up_valid : valid_reg;
    assign up_stall   = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bulk-only CBW to CSW decoder
// Drives command wrappers through the valid/stall input channel, computes
// the status wrapper each one should produce, and compares every status
// transfer field by field in order, under random sender gaps and receiver
// stalls, including one long receiver hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------

module tb_top
    import bot_pkg::*;
();

    // Data phase direction, as seen by the host or the device
    typedef enum logic [1:0] {
        XFER_NONE,
        XFER_IN,
        XFER_OUT
    } xfer_dir_t;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_FREE,
        RX_LIGHT,
        RX_PERIODIC,
        RX_HEAVY
    } rx_mode_t;

    class status_scoreboard_t #(parameter int unsigned SECTOR_BYTES = 512);

        csw_t        pending_csw[$];
        int unsigned mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // Decode one wrapper and classify it into a bulk-only case
        function csw_t predict_status(cbw_t c);
            csw_t        r;
            logic [7:0]  op;
            logic [31:0] dev_len;
            logic [31:0] alloc;
            logic [15:0] blocks;
            xfer_dir_t   dev_dir;
            xfer_dir_t   host_dir;
            logic        known;

            r = '0;
            if (c.transfer_bytes != CBW_SIZE || c.cbw_signature != CBW_SIG)
            begin
                r.result_kind = KIND_INVALID;
                return r;
            end

            r.result_kind = KIND_CSW;
            r.csw_tag     = c.cbw_tag;
            op            = c.cdb_head[7:0];
            dev_len       = '0;
            dev_dir       = XFER_NONE;
            known         = 1'b1;

            unique case (op)
                OP_INQUIRY:
                begin
                    dev_dir = XFER_IN;
                    if (c.cdb_head[8])
                    begin
                        // vital product data: only the serial page is served
                        if (c.cdb_head[23:16] == VPD_SERIAL_PAGE)
                        begin
                            dev_len       = 32'(SERIAL_LEN);
                            r.data_source = SRC_SERIAL;
                        end
                    end
                    else
                    begin
                        alloc         = {16'h0, c.cdb_head[31:24], c.cdb_head[39:32]};
                        dev_len       = (alloc < 32'(INQUIRY_LEN)) ? alloc
                                                                   : 32'(INQUIRY_LEN);
                        r.data_source = SRC_INQUIRY;
                    end
                end
                OP_TEST_UNIT_READY:
                begin
                end
                OP_READ_FMT_CAP:
                begin
                    dev_dir       = XFER_IN;
                    dev_len       = 32'(FMT_CAP_LEN);
                    r.data_source = SRC_FMT_CAP;
                end
                OP_READ_CAPACITY:
                begin
                    dev_dir       = XFER_IN;
                    dev_len       = 32'(CAPACITY_LEN);
                    r.data_source = SRC_CAPACITY;
                end
                OP_MODE_SENSE6:
                begin
                    alloc         = {24'h0, c.cdb_head[39:32]};
                    dev_dir       = XFER_IN;
                    dev_len       = (alloc >= 32'(MODE_HDR_LEN)) ? 32'(MODE_HDR_LEN)
                                                                 : alloc;
                    r.data_source = SRC_MODE_HDR;
                end
                OP_READ10:
                begin
                    blocks         = {c.cdb_head[63:56], c.cdb_byte8};
                    r.read_lba     = {c.cdb_head[23:16], c.cdb_head[31:24],
                                      c.cdb_head[39:32], c.cdb_head[47:40]};
                    r.sector_count = blocks;
                    dev_len        = 32'(blocks) * 32'(SECTOR_BYTES);
                    dev_dir        = XFER_IN;
                    r.data_source  = SRC_SECTORS;
                end
                default:
                begin
                    known = 1'b0;
                end
            endcase

            r.csw_status  = ST_PASS;
            r.csw_residue = c.host_length - dev_len;

            if (!known)
            begin
                r.csw_status  = ST_FAIL;
                r.csw_residue = c.host_length;
            end
            else
            begin
                if (c.host_length == '0)
                    host_dir = XFER_NONE;
                else
                    host_dir = c.host_dir_in ? XFER_IN : XFER_OUT;

                if (host_dir == XFER_NONE)
                begin
                    r.csw_residue = '0;
                    if (dev_dir != XFER_NONE)
                        r.csw_status = ST_PHASE;
                end
                else if (dev_dir == XFER_NONE)
                begin
                    r.halt_in     = (host_dir == XFER_IN);
                    r.halt_out    = (host_dir == XFER_OUT);
                    r.csw_residue = c.host_length;
                end
                else if (dev_dir != host_dir)
                begin
                    r.halt_in     = (host_dir == XFER_IN);
                    r.halt_out    = (host_dir == XFER_OUT);
                    r.csw_status  = ST_PHASE;
                    r.csw_residue = '0;
                end
                else if (c.host_length > dev_len)
                begin
                    r.halt_in     = (host_dir == XFER_IN);
                    r.halt_out    = (host_dir == XFER_OUT);
                    r.csw_residue = c.host_length - dev_len;
                end
                else if (c.host_length == dev_len)
                begin
                    r.csw_residue = '0;
                end
                else
                begin
                    r.csw_status  = ST_PHASE;
                    r.csw_residue = c.host_length;
                end
            end

            r.data_length = dev_len[24:0];
            return r;
        endfunction

        function void note_command(cbw_t c);
            pending_csw.push_back(predict_status(c));
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field,
                         want, got);
        endfunction

        function void check_status(csw_t got);
            csw_t want;

            if (pending_csw.size() == 0)
            begin
                flag("unexpected status, tag", '0, got.csw_tag);
                return;
            end
            want = pending_csw.pop_front();
            if (got.result_kind !== want.result_kind)
                flag("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            if (got.csw_tag !== want.csw_tag)
                flag("csw_tag", want.csw_tag, got.csw_tag);
            if (got.csw_residue !== want.csw_residue)
                flag("csw_residue", want.csw_residue, got.csw_residue);
            if (got.csw_status !== want.csw_status)
                flag("csw_status", 32'(want.csw_status), 32'(got.csw_status));
            if (got.halt_in !== want.halt_in)
                flag("halt_in", 32'(want.halt_in), 32'(got.halt_in));
            if (got.halt_out !== want.halt_out)
                flag("halt_out", 32'(want.halt_out), 32'(got.halt_out));
            if (got.data_source !== want.data_source)
                flag("data_source", 32'(want.data_source), 32'(got.data_source));
            if (got.data_length !== want.data_length)
                flag("data_length", 32'(want.data_length), 32'(got.data_length));
            if (got.read_lba !== want.read_lba)
                flag("read_lba", want.read_lba, got.read_lba);
            if (got.sector_count !== want.sector_count)
                flag("sector_count", 32'(want.sector_count), 32'(got.sector_count));
        endfunction

        function int unsigned pending();
            return pending_csw.size();
        endfunction

        function bit clean();
            return (mismatch_count == 0) && (pending_csw.size() == 0);
        endfunction

    endclass

    localparam int unsigned BLOCK_BYTES  = 512;
    localparam int unsigned RANDOM_CMDS  = 1200;
    localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, in cycles
    localparam int unsigned DRAIN_CYCLES = 16;    // three stages plus margin
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic clk;
    logic rst_n;
    logic cbw_valid;
    logic cbw_stall;
    cbw_t cbw;
    logic csw_valid;
    logic csw_stall;
    csw_t csw;

    status_scoreboard_t #(BLOCK_BYTES) sb;

    int unsigned cycle_count;
    int unsigned burst_left;
    bit          hold_request;

    bulk_only_cbw_to_csw #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cbw_valid (cbw_valid),
        .cbw_stall (cbw_stall),
        .cbw       (cbw),
        .csw_valid (csw_valid),
        .csw_stall (csw_stall),
        .csw       (csw)
    );

    // ------------------------------------------------------------------------
    // Clock, time-zero values, and the run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cbw_valid    = 1'b0;
        cbw          = '0;
        csw_stall    = 1'b0;
        cycle_count  = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        sb           = new();
    end

    always #6 clk = ~clk;

    // Abort a hung run; a correct run finishes far below this count
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d status transfers outstanding",
                     cycle_count, sb.pending());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Monitors: sample both channels at the edge, before any update lands
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (cbw_valid && !cbw_stall)
            sb.note_command(cbw);
        if (csw_valid && !csw_stall)
            sb.check_status(csw);
    end

    // ------------------------------------------------------------------------
    // Command wrapper construction
    // ------------------------------------------------------------------------

    // Pack command block bytes 0..7, byte 0 lowest
    function automatic logic [63:0] cdb(logic [7:0] op, logic [7:0] b1, logic [7:0] b2,
                                        logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                        logic [7:0] b7);
        return {b7, 8'h00, b5, b4, b3, b2, b1, op};
    endfunction

    // Build a well-framed wrapper with a random tag
    function automatic cbw_t scsi_cmd(logic [63:0] head, logic [7:0] b8,
                                      logic [31:0] hlen, logic dir_in);
        cbw_t c;
        c.transfer_bytes = CBW_SIZE;
        c.cbw_signature  = CBW_SIG;
        c.cbw_tag        = $urandom;
        c.host_length    = hlen;
        c.host_dir_in    = dir_in;
        c.cdb_head       = head;
        c.cdb_byte8      = b8;
        return c;
    endfunction

    // Mostly well-formed commands with random content; the host length is
    // steered around the device length so every bulk-only case shows up.
    function automatic cbw_t random_command();
        cbw_t        c;
        csw_t        hint;
        logic [7:0]  op;
        int unsigned pick;

        c = scsi_cmd({$urandom, $urandom}, 8'($urandom_range(0, 255)), '0,
                     1'($urandom_range(0, 1)));

        pick = $urandom_range(0, 13);
        if (pick < 2)       op = OP_INQUIRY;
        else if (pick < 3)  op = OP_TEST_UNIT_READY;
        else if (pick < 4)  op = OP_READ_FMT_CAP;
        else if (pick < 5)  op = OP_READ_CAPACITY;
        else if (pick < 7)  op = OP_MODE_SENSE6;
        else if (pick < 10) op = OP_READ10;
        else                op = 8'($urandom_range(0, 255));
        c.cdb_head[7:0] = op;

        // Keep allocation and block counts mostly small so lengths can match
        if (op == OP_INQUIRY)
        begin
            if ($urandom_range(0, 1))
                c.cdb_head[23:16] = VPD_SERIAL_PAGE;
            if ($urandom_range(0, 3) != 0)
            begin
                c.cdb_head[31:24] = 8'h00;
                c.cdb_head[39:32] = 8'($urandom_range(0, 60));
            end
        end
        else if (op == OP_MODE_SENSE6)
        begin
            if ($urandom_range(0, 1))
                c.cdb_head[39:32] = 8'($urandom_range(0, 8));
        end
        else if (op == OP_READ10)
        begin
            if ($urandom_range(0, 3) != 0)
                c.cdb_head[63:56] = 8'h00;
            if ($urandom_range(0, 1))
                c.cdb_byte8 = 8'($urandom_range(0, 16));
        end

        hint = sb.predict_status(c);
        pick = $urandom_range(0, 9);
        if (pick < 2)
            c.host_length = '0;
        else if (pick < 6)
            c.host_length = {7'h0, hint.data_length} + 32'($urandom_range(0, 2)) - 32'd1;
        else if (pick < 8)
            c.host_length = 32'($urandom_range(0, 64));
        else
            c.host_length = $urandom;

        // Break the framing on a minority of transfers
        pick = $urandom_range(0, 99);
        if (pick < 4)
            c.transfer_bytes = 10'($urandom_range(0, 512));
        else if (pick < 8)
            c.cbw_signature = $urandom;
        else if (pick < 11)
            c.cbw_signature = CBW_SIG ^ (32'd1 << $urandom_range(0, 31));
        else if (pick < 13)
            c.transfer_bytes = $urandom_range(0, 1) ? CBW_SIZE + 10'd1 : CBW_SIZE - 10'd1;

        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Sender tasks
    // ------------------------------------------------------------------------

    // Offer one wrapper and hold it until the transfer happens
    task automatic send_cbw(input cbw_t c);
        cbw       <= c;
        cbw_valid <= 1'b1;
        @(posedge clk);
        while (cbw_stall)
            @(posedge clk);
    endtask

    // Close a burst with a random gap (possibly none), then open the next one
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                cbw_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: stall on a pattern picked anew after each random run, and
    // honor one long hold-off request so the pipeline fills and stalls back
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        rx_mode_t    mode;
        int unsigned run;

        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            run  = $urandom_range(16, 96);
            while (run > 0)
            begin
                @(posedge clk);
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    csw_stall   <= 1'b1;
                    repeat (LONG_HOLD - 1)
                        @(posedge clk);
                end
                else
                begin
                    unique case (mode)
                        RX_FREE:     csw_stall <= 1'b0;
                        RX_LIGHT:    csw_stall <= ($urandom_range(0, 3) == 0);
                        RX_PERIODIC: csw_stall <= (run % 3 == 0);
                        default:     csw_stall <= ($urandom_range(0, 9) < 7);
                    endcase
                end
                run--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        cbw_t c;

        // Hold reset, then release it on an edge
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Test unit ready: no data, host none / in / out; tag extremes
        c = scsi_cmd(cdb(OP_TEST_UNIT_READY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                     8'h00, 32'd0, 1'b1);
        c.cbw_tag = 32'h0000_0000;
        pace_sender();
        send_cbw(c);
        c = scsi_cmd(cdb(OP_TEST_UNIT_READY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                     8'h00, 32'h200, 1'b1);
        c.cbw_tag = 32'hFFFF_FFFF;
        pace_sender();
        send_cbw(c);
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_TEST_UNIT_READY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                          8'h00, 32'd13, 1'b0));

        // Inquiry: exact, clipped allocation, short allocation, serial page,
        // unknown vital product page, and serial page against a host OUT
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_INQUIRY, 8'h00, 8'h00, 8'h00, 8'h24, 8'h00, 8'h00), 8'h00,
                          32'd36, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_INQUIRY, 8'hFE, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00), 8'h00,
                          32'hFF, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_INQUIRY, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00), 8'h00,
                          32'd36, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_INQUIRY, 8'h01, VPD_SERIAL_PAGE, 8'h00, 8'h00, 8'h00, 8'h00),
                          8'h00, 32'd12, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_INQUIRY, 8'h01, 8'h83, 8'h00, 8'h00, 8'h00, 8'h00), 8'h00,
                          32'd64, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_INQUIRY, 8'h01, VPD_SERIAL_PAGE, 8'h00, 8'h00, 8'h00, 8'h00),
                          8'h00, 32'd12, 1'b0));

        // Fixed-length replies, including the host expecting nothing or less
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_READ_FMT_CAP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                          8'h00, 32'd12, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_READ_FMT_CAP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                          8'h00, 32'd0, 1'b0));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_READ_CAPACITY, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                          8'h00, 32'd4, 1'b1));

        // Mode sense: clipped header, short allocation, zero allocation
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_MODE_SENSE6, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00),
                          8'h00, 32'd4, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_MODE_SENSE6, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00),
                          8'h00, 32'd192, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_MODE_SENSE6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00),
                          8'h00, 32'd0, 1'b1));

        // Read 10: zero blocks, largest address and count, exact, host OUT
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_READ10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 8'h00,
                          32'd0, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_READ10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 8'hFF,
                          32'hFFFF_FFFF, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_READ10, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00), 8'h08,
                          32'd4096, 1'b1));
        pace_sender();
        send_cbw(scsi_cmd(cdb(OP_READ10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 8'h01,
                          32'h100, 1'b0));

        // Unsupported opcodes
        pace_sender();
        send_cbw(scsi_cmd(cdb(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 8'h00,
                          32'hFFFF_FFFF, 1'b0));
        pace_sender();
        send_cbw(scsi_cmd(cdb(8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 8'h00,
                          32'd0, 1'b1));

        // Broken framing: short, largest transfer, status signature, all zero
        c = scsi_cmd(cdb(OP_INQUIRY, 8'h00, 8'h00, 8'h00, 8'h24, 8'h00, 8'h00), 8'h00,
                     32'd36, 1'b1);
        c.transfer_bytes = CBW_SIZE - 10'd1;
        pace_sender();
        send_cbw(c);
        c.transfer_bytes = 10'd512;
        c.cbw_signature  = 32'hFFFF_FFFF;
        pace_sender();
        send_cbw(c);
        c.transfer_bytes = CBW_SIZE;
        c.cbw_signature  = 32'h5342_5355;
        pace_sender();
        send_cbw(c);
        pace_sender();
        send_cbw('0);

        // Random traffic; ask for the long receiver hold partway through
        for (int unsigned i = 0; i < RANDOM_CMDS; i++)
        begin
            if (i == 200)
                hold_request = 1'b1;
            pace_sender();
            send_cbw(random_command());
        end
        cbw_valid <= 1'b0;
        // Let the monitor note the last transfer before counting what is left
        @(posedge clk);

        // Drain: wait for every status, then watch for stray transfers
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (sb.clean())
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
